// ===== src/vfd_pkg.sv =====
package vfd_pkg;

   localparam int unsigned VARINT_MAX_BYTES = 5;
   localparam logic [31:0] COMPRESS_BITS = 32'h0000_0070;
   localparam logic [7:0] FILE_HEADER_BYTES_RESET = 8'd16;

   typedef enum logic [2:0] {
      PH_SKIP    = 3'd0,
      PH_CMD     = 3'd1,
      PH_TICK    = 3'd2,
      PH_SIZE    = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_HALTED  = 3'd5,
      PH_FAULT   = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      EV_SKIP      = 3'd0,
      EV_HDR_BYTE  = 3'd1,
      EV_HDR_DONE  = 3'd2,
      EV_PAYLOAD   = 3'd3,
      EV_IGNORED   = 3'd4,
      EV_TOO_LONG  = 3'd5,
      EV_TRUNCATED = 3'd6
   } event_kind_type;

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  skip_cnt;
      logic [31:0] acc;
      logic [2:0]  idx;
      logic [31:0] cmd;
      logic [31:0] tick;
      logic [31:0] remaining;
      logic        compressed;
   } state_type;

   typedef struct packed {
      event_kind_type event_kind;
      logic [31:0]    frame_command;
      logic [31:0]    frame_tick;
      logic [31:0]    frame_size;
      logic           frame_compressed;
      logic [7:0]     payload_byte;
      logic           payload_last;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:      PH_SKIP,
      skip_cnt:   8'd0,
      acc:        32'd0,
      idx:        3'd0,
      cmd:        32'd0,
      tick:       32'd0,
      remaining:  32'd0,
      compressed: 1'b0
   };

endpackage

// ===== src/vfd_channels.sv =====
interface vfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   logic       end_of_file;

   modport source (output valid, output stream_byte, output end_of_file, input ready);
   modport sink (input valid, input stream_byte, input end_of_file, output ready);
endinterface

interface vfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_kind;
   logic [31:0] frame_command;
   logic [31:0] frame_tick;
   logic [31:0] frame_size;
   logic        frame_compressed;
   logic [7:0]  payload_byte;
   logic        payload_last;

   modport source (output valid, output event_kind, output frame_command,
                   output frame_tick, output frame_size, output frame_compressed,
                   output payload_byte, output payload_last, input ready);
   modport sink (input valid, input event_kind, input frame_command,
                 input frame_tick, input frame_size, input frame_compressed,
                 input payload_byte, input payload_last, output ready);
endinterface

interface vfd_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] file_header_bytes;

   modport source (output valid, output file_header_bytes, input ready);
   modport sink (input valid, input file_header_bytes, output ready);
endinterface

// ===== src/vfd_step.sv =====
module vfd_step (
   input  vfd_pkg::state_type  cur,
   input  logic [7:0]          hdr_bytes,
   input  logic [7:0]          stream_byte,
   input  logic                end_of_file,
   output vfd_pkg::state_type  nxt,
   output vfd_pkg::result_type res
);
   import vfd_pkg::*;

   phase_type   ph;
   logic [31:0] part;
   logic [31:0] acc_new;
   logic [2:0]  idx_inc;
   logic        open_frame;

   always_comb begin
      case (cur.idx)
         3'd0:    part = {25'd0, stream_byte[6:0]};
         3'd1:    part = {18'd0, stream_byte[6:0], 7'd0};
         3'd2:    part = {11'd0, stream_byte[6:0], 14'd0};
         3'd3:    part = {4'd0, stream_byte[6:0], 21'd0};
         3'd4:    part = {stream_byte[3:0], 28'd0};
         default: part = 32'd0;
      endcase
   end

   assign acc_new = cur.acc | part;
   assign idx_inc = cur.idx + 3'd1;

   always_comb begin
      nxt = cur;
      res = '0;
      res.event_kind = EV_SKIP;
      open_frame = 1'b0;

      ph = cur.phase;
      if (ph == PH_SKIP && cur.skip_cnt >= hdr_bytes) begin
         ph = PH_CMD;
      end
      nxt.phase = ph;

      unique case (ph) inside
         PH_SKIP: begin
            nxt.skip_cnt = cur.skip_cnt + 8'd1;
            res.event_kind = EV_SKIP;
         end
         PH_CMD, PH_TICK, PH_SIZE: begin
            nxt.acc = acc_new;
            if (stream_byte[7]) begin
               if (idx_inc >= 3'(VARINT_MAX_BYTES)) begin
                  nxt.phase = PH_FAULT;
                  res.event_kind = EV_TOO_LONG;
               end else begin
                  nxt.idx = idx_inc;
                  res.event_kind = EV_HDR_BYTE;
               end
            end else begin
               nxt.acc = '0;
               nxt.idx = '0;
               if (ph == PH_CMD) begin
                  nxt.cmd = acc_new & ~COMPRESS_BITS;
                  nxt.compressed = |(acc_new & COMPRESS_BITS);
                  nxt.phase = PH_TICK;
                  res.event_kind = EV_HDR_BYTE;
               end else if (ph == PH_TICK) begin
                  nxt.tick = acc_new;
                  nxt.phase = PH_SIZE;
                  res.event_kind = EV_HDR_BYTE;
               end else begin
                  res.event_kind = EV_HDR_DONE;
                  res.frame_command = cur.cmd;
                  res.frame_tick = cur.tick;
                  res.frame_size = acc_new;
                  res.frame_compressed = cur.compressed;
                  if (cur.cmd == 32'd0) begin
                     nxt.phase = PH_HALTED;
                  end else if (acc_new == 32'd0) begin
                     nxt.phase = PH_CMD;
                  end else begin
                     nxt.remaining = acc_new;
                     nxt.phase = PH_PAYLOAD;
                  end
               end
            end
         end
         PH_PAYLOAD: begin
            res.event_kind = EV_PAYLOAD;
            res.payload_byte = stream_byte;
            res.payload_last = (cur.remaining == 32'd1);
            nxt.remaining = cur.remaining - 32'd1;
            if (cur.remaining == 32'd1) begin
               nxt.phase = PH_CMD;
            end
         end
         default: begin
            res.event_kind = EV_IGNORED;
         end
      endcase

      if (end_of_file) begin
         open_frame = nxt.phase == PH_TICK || nxt.phase == PH_SIZE ||
                      nxt.phase == PH_PAYLOAD ||
                      (nxt.phase == PH_CMD && nxt.idx != 3'd0);
         if (open_frame && res.event_kind != EV_TOO_LONG) begin
            res = '0;
            res.event_kind = EV_TRUNCATED;
         end
         nxt = STATE_RESET;
      end
   end

endmodule

// ===== src/varint_frame_header_deframer.sv =====
// Deframer for a recording file: skips the file header, then splits the rest
// into frames of three varints (command, tick, size) followed by the payload.
// req_ch takes one file byte per request, with end_of_file on the last byte
// of a file. rsp_ch gives exactly one result per request: a skip, header byte,
// header done, payload, ignored, varint too long or truncated event.
// csr_ch writes file_header_bytes; csr_ch.ready is always high. The user must
// make writes only while no request is in flight; the block does not enforce it.
// A request accepted at one edge has its result registered and shown on
// rsp_ch in the next cycle. Throughput is one request per cycle while the
// receiver keeps up, set by the single parse step before the result register.
// When the receiver stalls, the result register holds its value and
// req_ch.ready stays high only in the cycle the held result is taken.
// Reset (synchronous, active high) returns the parser to the header skip,
// sets file_header_bytes to 16 and empties the result register; the block
// takes requests in the first cycle after reset. After the last byte of a
// file the parser returns to the header skip on its own.
module varint_frame_header_deframer (
   input logic       clock,
   input logic       reset,
   vfd_req_if.sink   req_ch,
   vfd_rsp_if.source rsp_ch,
   vfd_csr_if.sink   csr_ch
);
   import vfd_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   result_type rsp_ff;
   result_type rsp_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] hdr_bytes_ff;
   logic [7:0] hdr_bytes_in;
   logic       req_take;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_take = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   vfd_step u_step (
      .cur         (state_ff),
      .hdr_bytes   (hdr_bytes_ff),
      .stream_byte (req_ch.stream_byte),
      .end_of_file (req_ch.end_of_file),
      .nxt         (state_in),
      .res         (rsp_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      hdr_bytes_in = hdr_bytes_ff;
      if (csr_ch.valid) begin
         hdr_bytes_in = csr_ch.file_header_bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
         hdr_bytes_ff <= FILE_HEADER_BYTES_RESET;
      end else begin
         if (req_take) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
         hdr_bytes_ff <= hdr_bytes_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.event_kind = rsp_ff.event_kind;
   assign rsp_ch.frame_command = rsp_ff.frame_command;
   assign rsp_ch.frame_tick = rsp_ff.frame_tick;
   assign rsp_ch.frame_size = rsp_ff.frame_size;
   assign rsp_ch.frame_compressed = rsp_ff.frame_compressed;
   assign rsp_ch.payload_byte = rsp_ff.payload_byte;
   assign rsp_ch.payload_last = rsp_ff.payload_last;

endmodule

// ===== sim/tb_varint_frame_header_deframer.sv =====
import vfd_pkg::*;

class deframer_scoreboard;
   state_type  parse;
   logic [7:0] header_len;
   result_type expected_q[$];
   int         failures;
   int         checked;
   int         kind_count[7];

   function new();
      parse = STATE_RESET;
      header_len = FILE_HEADER_BYTES_RESET;
      failures = 0;
      checked = 0;
      foreach (kind_count[k]) kind_count[k] = 0;
   endfunction

   function void set_header_len(logic [7:0] v);
      header_len = v;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   // one request in, one predicted result out
   function void note_request(logic [7:0] b, logic eof);
      result_type  r;
      logic [2:0]  idx;
      logic [31:0] v;
      logic        open_frame;
      r = '0;
      r.event_kind = EV_SKIP;
      if (parse.phase == PH_SKIP && parse.skip_cnt >= header_len) parse.phase = PH_CMD;
      case (parse.phase)
         PH_SKIP: begin
            parse.skip_cnt = parse.skip_cnt + 8'd1;
            r.event_kind = EV_SKIP;
         end
         PH_CMD, PH_TICK, PH_SIZE: begin
            idx = parse.idx;
            if (idx < VARINT_MAX_BYTES)
               parse.acc = parse.acc | ({25'd0, b[6:0]} << (7 * idx));
            idx = idx + 3'd1;
            if (b[7]) begin
               if (idx >= VARINT_MAX_BYTES) begin
                  parse.phase = PH_FAULT;
                  r.event_kind = EV_TOO_LONG;
               end else begin
                  parse.idx = idx;
                  r.event_kind = EV_HDR_BYTE;
               end
            end else begin
               v = parse.acc;
               parse.acc = '0;
               parse.idx = '0;
               case (parse.phase)
                  PH_CMD: begin
                     parse.cmd = v & ~COMPRESS_BITS;
                     parse.compressed = |(v & COMPRESS_BITS);
                     parse.phase = PH_TICK;
                     r.event_kind = EV_HDR_BYTE;
                  end
                  PH_TICK: begin
                     parse.tick = v;
                     parse.phase = PH_SIZE;
                     r.event_kind = EV_HDR_BYTE;
                  end
                  default: begin
                     r.event_kind = EV_HDR_DONE;
                     r.frame_command = parse.cmd;
                     r.frame_tick = parse.tick;
                     r.frame_size = v;
                     r.frame_compressed = parse.compressed;
                     if (parse.cmd == 32'd0) parse.phase = PH_HALTED;
                     else if (v == 32'd0) parse.phase = PH_CMD;
                     else begin
                        parse.remaining = v;
                        parse.phase = PH_PAYLOAD;
                     end
                  end
               endcase
            end
         end
         PH_PAYLOAD: begin
            r.event_kind = EV_PAYLOAD;
            r.payload_byte = b;
            r.payload_last = (parse.remaining == 32'd1);
            parse.remaining = parse.remaining - 32'd1;
            if (parse.remaining == 32'd0) parse.phase = PH_CMD;
         end
         default: r.event_kind = EV_IGNORED;
      endcase
      if (eof) begin
         open_frame = parse.phase == PH_TICK || parse.phase == PH_SIZE ||
                      parse.phase == PH_PAYLOAD ||
                      (parse.phase == PH_CMD && parse.idx != 3'd0);
         if (open_frame && r.event_kind != EV_TOO_LONG) begin
            r = '0;
            r.event_kind = EV_TRUNCATED;
         end
         parse = STATE_RESET;
      end
      expected_q.push_back(r);
   endfunction

   function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endfunction

   function void check_result(result_type got);
      result_type want;
      if (expected_q.size() == 0) begin
         $error("event_kind: expected nothing, got %0d", got.event_kind);
         failures++;
         return;
      end
      want = expected_q.pop_front();
      checked++;
      kind_count[want.event_kind]++;
      compare_field("event_kind", want.event_kind, got.event_kind);
      compare_field("frame_command", want.frame_command, got.frame_command);
      compare_field("frame_tick", want.frame_tick, got.frame_tick);
      compare_field("frame_size", want.frame_size, got.frame_size);
      compare_field("frame_compressed", want.frame_compressed, got.frame_compressed);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("payload_last", want.payload_last, got.payload_last);
   endfunction
endclass

module tb_varint_frame_header_deframer;

   localparam int STALL_LIMIT = 3000;
   localparam int PHASE_BYTES = 215;

   logic clock;
   logic reset;

   vfd_req_if req_ch();
   vfd_rsp_if rsp_ch();
   vfd_csr_if csr_ch();

   varint_frame_header_deframer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   deframer_scoreboard sb;
   logic [8:0] file_q[$];
   logic       req_gaps;
   logic       rsp_gaps;
   logic       hold_off_req;
   int         idle_cycles;
   int         bytes_sent;
   int         files_sent;

   always #6 clock = ~clock;

   always @(posedge clock) begin
      result_type got;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.event_kind = event_kind_type'(rsp_ch.event_kind);
            got.frame_command = rsp_ch.frame_command;
            got.frame_tick = rsp_ch.frame_tick;
            got.frame_size = rsp_ch.frame_size;
            got.frame_compressed = rsp_ch.frame_compressed;
            got.payload_byte = rsp_ch.payload_byte;
            got.payload_last = rsp_ch.payload_last;
            sb.check_result(got);
         end
         if (req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.stream_byte, req_ch.end_of_file);
         if (csr_ch.valid && csr_ch.ready)
            sb.set_header_len(csr_ch.file_header_bytes);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // result receiver, with a long hold-off when hold_off_req is set
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (150) @(negedge clock);
         end
         rsp_ch.ready <= !(rsp_gaps && $urandom_range(0, 99) < 32);
      end
   end

   task automatic send_req(input logic [8:0] item);
      while (req_gaps && $urandom_range(0, 99) < 32) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.stream_byte <= item[7:0];
      req_ch.end_of_file <= item[8];
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_file();
      foreach (file_q[i]) send_req(file_q[i]);
      files_sent++;
   endtask

   task automatic wait_results_done();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_header_len(input logic [7:0] v);
      csr_ch.valid <= 1'b1;
      csr_ch.file_header_bytes <= v;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic void put_varint(input logic [31:0] v, input int pad);
      int          n;
      int          total;
      logic [31:0] t;
      logic [7:0]  b;
      n = 1;
      t = v >> 7;
      while (t != 0) begin
         n++;
         t = t >> 7;
      end
      total = (n + pad > VARINT_MAX_BYTES) ? VARINT_MAX_BYTES : n + pad;
      for (int i = 0; i < total; i++) begin
         b = 8'(v >> (7 * i)) & 8'h7F;
         // bits above 31 in the fifth byte are dropped by the block
         if (i == 4 && $urandom_range(0, 1) == 1) b[6:4] = 3'($urandom_range(0, 7));
         if (i < total - 1) b[7] = 1'b1;
         file_q.push_back({1'b0, b});
      end
   endfunction

   function automatic int rand_pad();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0;
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 127);
         1: return $urandom_range(0, 16383);
         2: return $urandom;
         3: return 32'hFFFF_FFFF;
         default: return ($urandom_range(0, 1) == 1) ? 32'd128 : 32'd0;
      endcase
   endfunction

   function automatic void put_frame();
      logic [31:0] cmd;
      logic [31:0] size;
      int          r;
      r = $urandom_range(0, 99);
      if (r < 5) cmd = 32'd0;
      else if (r < 15) cmd = $urandom;
      else cmd = $urandom_range(1, 15) | ($urandom_range(0, 7) << 4);
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
      put_varint(cmd, rand_pad());
      put_varint(rand_value(), rand_pad());
      put_varint(size, rand_pad());
      repeat (size) file_q.push_back({1'b0, 8'($urandom)});
   endfunction

   function automatic void build_file(input int header_len);
      int frames;
      int shape;
      int keep;
      file_q.delete();
      repeat (header_len) file_q.push_back({1'b0, 8'($urandom)});
      frames = $urandom_range(1, 5);
      shape = $urandom_range(0, 99);
      for (int f = 0; f < frames; f++) begin
         if (shape < 10 && f == frames - 1)
            repeat ($urandom_range(5, 7)) file_q.push_back({1'b1, 1'b1, 7'($urandom)} & 9'h0FF);
         else
            put_frame();
      end
      if (shape >= 10 && shape < 22)
         repeat ($urandom_range(1, 8)) file_q.push_back({1'b0, 8'($urandom)});
      if (shape >= 22 && shape < 40) begin
         keep = $urandom_range(1, file_q.size());
         while (file_q.size() > keep) void'(file_q.pop_back());
      end
      if (file_q.size() == 0) file_q.push_back({1'b0, 8'($urandom)});
      file_q[file_q.size() - 1][8] = 1'b1;
   endfunction

   initial begin
      logic [7:0] header_plan[8];
      logic [7:0] header_len;
      int         phase_bytes;
      sb = new();
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.stream_byte = 8'd0;
      req_ch.end_of_file = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.file_header_bytes = 8'd0;
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      hold_off_req = 1'b0;
      bytes_sent = 0;
      files_sent = 0;
      header_plan = '{8'd0, 8'd1, 8'd2, 8'd16, 8'd3, 8'd255, 8'd4, 8'd0};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // no file header: compressed frame with payload, wide tick, empty frame, stop
      write_header_len(8'd0);
      file_q = '{9'h075, 9'h000, 9'h002, 9'h0FF, 9'h000,
                 9'h001, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h07F, 9'h000,
                 9'h000, 9'h000, 9'h000, 9'h1AA};
      send_file();
      // varint too long, then end of file in the ignored tail
      file_q = '{9'h080, 9'h080, 9'h080, 9'h080, 9'h080, 9'h17F};
      send_file();
      // file ends before the size varint
      file_q = '{9'h001, 9'h105};
      send_file();
      // header length lowered while skipping, then file ends inside the command
      wait_results_done();
      write_header_len(8'd3);
      send_req(9'h0A5);
      send_req(9'h05A);
      wait_results_done();
      write_header_len(8'd1);
      send_req(9'h181);
      // file ends during the header skip
      send_req(9'h1C3);

      for (int p = 0; p < 8; p++) begin
         header_len = (p == 4) ? 8'($urandom_range(3, 40)) : header_plan[p];
         wait_results_done();
         write_header_len(header_len);
         req_gaps = (p != 2);
         rsp_gaps = (p != 2);
         if (p == 3) hold_off_req = 1'b1;
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            build_file(header_len);
            phase_bytes += file_q.size();
            send_file();
         end
      end

      wait_results_done();
      repeat (10) @(posedge clock);
      $display("sent %0d bytes in %0d files over several header lengths, %0d results checked",
               bytes_sent, files_sent, sb.checked);
      $display("frame headers %0d, payload bytes %0d, ignored %0d, too long %0d, truncated %0d",
               sb.kind_count[EV_HDR_DONE], sb.kind_count[EV_PAYLOAD],
               sb.kind_count[EV_IGNORED], sb.kind_count[EV_TOO_LONG],
               sb.kind_count[EV_TRUNCATED]);
      if (sb.failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== varint_frame_header_deframer.f =====
src/vfd_pkg.sv
src/vfd_channels.sv
src/vfd_step.sv
src/varint_frame_header_deframer.sv
sim/tb_varint_frame_header_deframer.sv
